// ===== design/fpa_pkg.sv =====
// Shared command codes and pipeline sideband type for the fixed-point ALU.
`default_nettype none
package fpa_pkg;

    // Operation codes carried in the command field
    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_MIN      = 4'd4,
        CMD_MAX      = 4'd5,
        CMD_INC      = 4'd6,
        CMD_DEC      = 4'd7,
        CMD_TO_INT   = 4'd8,
        CMD_FROM_INT = 4'd9
    } fpa_cmd_t;

    localparam int unsigned WORD_W = 32;

    // Everything that rides alongside the divider stages
    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic              a_less;
        logic              a_equal;
        logic              a_greater;
        logic              is_div;
        logic              div_zero;
        logic              quot_neg;
    } fpa_side_t;

endpackage
`default_nettype wire

// ===== design/fpa_in_if.sv =====
// Request channel of the fixed-point ALU: command and two raw operands.
`default_nettype none
interface fpa_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         command;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, output command, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input command, input operand_a, input operand_b,
                    output ready);
endinterface
`default_nettype wire

// ===== design/fpa_out_if.sv =====
// Response channel of the fixed-point ALU: result and flags.
`default_nettype none
interface fpa_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result;
    logic               a_less;
    logic               a_equal;
    logic               a_greater;
    logic               divide_by_zero;

    modport source (output valid, output result, output a_less, output a_equal,
                    output a_greater, output divide_by_zero, input ready);
    modport sink   (input valid, input result, input a_less, input a_equal,
                    input a_greater, input divide_by_zero, output ready);
endinterface
`default_nettype wire

// ===== design/fixed_point_alu_unit.sv =====
// Top level of the pipelined signed fixed-point ALU.
//
//  channel   | dir | payload
//  ----------+-----+--------------------------------------------------------
//  request   | in  | command[3:0], operand_a[31:0], operand_b[31:0]
//  response  | out | result[31:0], a_less, a_equal, a_greater, divide_by_zero
//
// One request per cycle unless the pipe holds (below); every command takes the
// same path through all stages, including the divider, which resolves one
// quotient bit per stage.
// All stages advance together; when the output register holds an untaken
// response the whole pipe holds and request.ready drops.
// rst_n clears only the stage valid bits.
`default_nettype none
module fixed_point_alu_unit
    import fpa_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 8
)(
    input  wire logic clk,
    input  wire logic rst_n,
    fpa_in_if.sink    request,
    fpa_out_if.source response
);

    localparam int unsigned NUM_W = WORD_W + FRAC_BITS;

    logic en;

    // Stage 0: input register
    logic                     s0_valid_reg;
    logic [3:0]               s0_cmd_reg;
    logic signed [WORD_W-1:0] s0_a_reg;
    logic signed [WORD_W-1:0] s0_b_reg;

    // Stage 1: multiply, simple ops, divider operand prep
    logic                     s1_valid_reg;
    logic signed [63:0]       s1_prod_reg;
    logic                     s1_is_mul_reg;
    fpa_side_t                s1_side_reg;
    logic [NUM_W-1:0]         s1_num_reg;
    logic [WORD_W-1:0]        s1_den_reg;

    // Stage 2: product scaling
    logic                     s2_valid_reg;
    fpa_side_t                s2_side_reg;
    logic [NUM_W-1:0]         s2_num_reg;
    logic [WORD_W-1:0]        s2_den_reg;

    // Output register
    logic                     out_valid_reg;
    logic [WORD_W-1:0]        out_result_reg;
    logic                     out_less_reg;
    logic                     out_equal_reg;
    logic                     out_greater_reg;
    logic                     out_dz_reg;

    logic                     dv_valid;
    logic [WORD_W-1:0]        dv_quot;
    fpa_side_t                dv_side;

    assign en            = !out_valid_reg || response.ready;
    assign request.ready = en;

    // stage 1 combinational work
    logic signed [63:0]  prod_next;
    logic [WORD_W-1:0]   simple_next;
    logic [WORD_W-1:0]   a_mag;
    logic [WORD_W-1:0]   b_mag;
    fpa_side_t           side_next;
    logic                lt;
    logic                eq;

    assign prod_next = s0_a_reg * s0_b_reg;
    assign lt        = (s0_a_reg < s0_b_reg);
    assign eq        = (s0_a_reg == s0_b_reg);
    assign a_mag     = s0_a_reg[WORD_W-1] ? (~s0_a_reg + 1'b1) : s0_a_reg;
    assign b_mag     = s0_b_reg[WORD_W-1] ? (~s0_b_reg + 1'b1) : s0_b_reg;

    always_comb
    begin
        unique case (fpa_cmd_t'(s0_cmd_reg))
            CMD_ADD:      simple_next = s0_a_reg + s0_b_reg;
            CMD_SUB:      simple_next = s0_a_reg - s0_b_reg;
            CMD_MIN:      simple_next = lt ? s0_a_reg : s0_b_reg;
            CMD_MAX:      simple_next = (!lt && !eq) ? s0_a_reg : s0_b_reg;
            CMD_INC:      simple_next = s0_a_reg + 32'sd1;
            CMD_DEC:      simple_next = s0_a_reg - 32'sd1;
            CMD_TO_INT:   simple_next = s0_a_reg >>> FRAC_BITS;
            CMD_FROM_INT: simple_next = s0_a_reg << FRAC_BITS;
            default:      simple_next = '0;
        endcase
    end

    always_comb
    begin
        side_next.result    = simple_next;
        side_next.a_less    = lt;
        side_next.a_equal   = eq;
        side_next.a_greater = !lt && !eq;
        side_next.is_div    = (s0_cmd_reg == CMD_DIV);
        side_next.div_zero  = (s0_cmd_reg == CMD_DIV) && (s0_b_reg == '0);
        side_next.quot_neg  = s0_a_reg[WORD_W-1] ^ s0_b_reg[WORD_W-1];
    end

    // stage 2 sideband: scaled product replaces the carried result for multiply
    fpa_side_t s2_side_next;

    always_comb
    begin
        s2_side_next = s1_side_reg;
        if (s1_is_mul_reg)
        begin
            s2_side_next.result = s1_prod_reg[FRAC_BITS+WORD_W-1:FRAC_BITS];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg  <= request.valid;
            s1_valid_reg  <= s0_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= dv_valid;
        end
    end

    // payload through stages 0..2
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_cmd_reg    <= request.command;
            s0_a_reg      <= request.operand_a;
            s0_b_reg      <= request.operand_b;

            s1_prod_reg   <= prod_next;
            s1_is_mul_reg <= (s0_cmd_reg == CMD_MUL);
            s1_side_reg   <= side_next;
            s1_num_reg    <= {a_mag, {FRAC_BITS{1'b0}}};
            s1_den_reg    <= b_mag;

            s2_side_reg   <= s2_side_next;
            s2_num_reg    <= s1_num_reg;
            s2_den_reg    <= s1_den_reg;
        end
    end

    fpa_div_pipe #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .in_num    (s2_num_reg),
        .in_den    (s2_den_reg),
        .in_side   (s2_side_reg),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_side  (dv_side)
    );

    // final select: signed quotient for divide, carried result otherwise
    logic [WORD_W-1:0] final_result;

    always_comb
    begin
        if (!dv_side.is_div)
            final_result = dv_side.result;
        else if (dv_side.div_zero)
            final_result = '0;
        else if (dv_side.quot_neg)
            final_result = ~dv_quot + 1'b1;
        else
            final_result = dv_quot;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_result_reg  <= final_result;
            out_less_reg    <= dv_side.a_less;
            out_equal_reg   <= dv_side.a_equal;
            out_greater_reg <= dv_side.a_greater;
            out_dz_reg      <= dv_side.div_zero;
        end
    end

    assign response.valid          = out_valid_reg;
    assign response.result         = out_result_reg;
    assign response.a_less         = out_less_reg;
    assign response.a_equal        = out_equal_reg;
    assign response.a_greater      = out_greater_reg;
    assign response.divide_by_zero = out_dz_reg;

    // checks
    a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot({out_less_reg, out_equal_reg, out_greater_reg}))
        else $error("compare flags not one-hot");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_dz_reg) |-> (out_result_reg == '0))
        else $error("divide by zero with nonzero result");

    a_dz_equal_impossible: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_dz_reg && out_equal_reg) |-> (out_less_reg == 1'b0))
        else $error("inconsistent flags on divide by zero");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(s0_valid_reg) && $stable(s2_valid_reg)))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire

// ===== design/fpa_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`default_nettype none
module fpa_div_pipe
    import fpa_pkg::*;
#(
    parameter int unsigned NUM_W = 40
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  in_num,
    input  wire logic [WORD_W-1:0] in_den,
    input  wire fpa_side_t         in_side,
    output logic                   out_valid,
    output logic [WORD_W-1:0]      out_quot,
    output fpa_side_t              out_side
);

    logic              valid_reg [NUM_W];
    logic [WORD_W:0]   rem_reg   [NUM_W];
    logic [NUM_W-1:0]  nq_reg    [NUM_W];
    logic [WORD_W-1:0] den_reg   [NUM_W];
    fpa_side_t         side_reg  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic              prev_valid;
        logic [WORD_W:0]   prev_rem;
        logic [NUM_W-1:0]  prev_nq;
        logic [WORD_W-1:0] prev_den;
        fpa_side_t         prev_side;
        logic [WORD_W:0]   rem_shift;
        logic [WORD_W:0]   den_ext;
        logic              ge;

        if (k == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_rem   = '0;
            assign prev_nq    = in_num;
            assign prev_den   = in_den;
            assign prev_side  = in_side;
        end
        else begin : g_next
            assign prev_valid = valid_reg[k-1];
            assign prev_rem   = rem_reg[k-1];
            assign prev_nq    = nq_reg[k-1];
            assign prev_den   = den_reg[k-1];
            assign prev_side  = side_reg[k-1];
        end

        // shift in next numerator bit, trial subtract
        assign rem_shift = {prev_rem[WORD_W-1:0], prev_nq[NUM_W-1]};
        assign den_ext   = {1'b0, prev_den};
        assign ge        = (rem_shift >= den_ext);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? (rem_shift - den_ext) : rem_shift;
                nq_reg[k]   <= {prev_nq[NUM_W-2:0], ge};
                den_reg[k]  <= prev_den;
                side_reg[k] <= prev_side;
            end
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign out_quot  = nq_reg[NUM_W-1][WORD_W-1:0];
    assign out_side  = side_reg[NUM_W-1];

endmodule
`default_nettype wire

// ===== test/fpa_channels.sv =====
// Testbench-side note: the channel interfaces come from the design files.
// This file holds the request and response record types used by the checker.
package fpa_tb_pkg;
    import fpa_pkg::*;

    // One request as the checker records it
    typedef struct packed {
        logic [3:0]         command;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } alu_request_t;

    // One response as the checker predicts it
    typedef struct packed {
        logic signed [31:0] result;
        logic               a_less;
        logic               a_equal;
        logic               a_greater;
        logic               divide_by_zero;
    } alu_response_t;
endpackage

// ===== test/fpa_checker.sv =====
// Checker: watches both channels, predicts each response and compares it.
module fpa_checker
    import fpa_pkg::*;
    import fpa_tb_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 8
)(
    input  logic clk,
    input  logic rst_n,
    fpa_in_if    request,
    fpa_out_if   response,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    alu_response_t expected_responses[$];

    // Compute the response for one request
    function automatic alu_response_t compute_response(alu_request_t req);
        alu_response_t r;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] wide;
        a = req.operand_a;
        b = req.operand_b;
        r = '0;
        case (req.command)
            CMD_ADD:      r.result = req.operand_a + req.operand_b;
            CMD_SUB:      r.result = req.operand_a - req.operand_b;
            CMD_MUL:
            begin
                wide = a * b;
                r.result = 32'(wide >>> FRAC_BITS);
            end
            CMD_DIV:
            begin
                if (b == 0)
                    r.divide_by_zero = 1'b1;
                else
                begin
                    wide = (a <<< FRAC_BITS) / b;
                    r.result = wide[31:0];
                end
            end
            CMD_MIN:      r.result = (a < b) ? req.operand_a : req.operand_b;
            CMD_MAX:      r.result = (a > b) ? req.operand_a : req.operand_b;
            CMD_INC:      r.result = req.operand_a + 32'sd1;
            CMD_DEC:      r.result = req.operand_a - 32'sd1;
            CMD_TO_INT:   r.result = req.operand_a >>> FRAC_BITS;
            CMD_FROM_INT: r.result = req.operand_a << FRAC_BITS;
            default:      r.result = '0;
        endcase
        r.a_less    = a < b;
        r.a_equal   = a == b;
        r.a_greater = a > b;
        return r;
    endfunction

    // Record requests and compare responses
    always @(posedge clk)
    begin
        alu_request_t req;
        alu_response_t want;
        if (rst_n)
        begin
            if (request.valid && request.ready)
            begin
                req.command   = request.command;
                req.operand_a = request.operand_a;
                req.operand_b = request.operand_b;
                expected_responses.push_back(compute_response(req));
            end
            if (response.valid && response.ready)
            begin
                if (expected_responses.size() == 0)
                begin
                    $display("%0t: unexpected response result=%h", $realtime,
                             response.result);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_responses.pop_front();
                    if (want !== {response.result, response.a_less, response.a_equal,
                                  response.a_greater, response.divide_by_zero})
                    begin
                        $display("%0t: mismatch expected res=%h lt=%b eq=%b gt=%b dz=%b",
                                 $realtime, want.result, want.a_less, want.a_equal,
                                 want.a_greater, want.divide_by_zero);
                        $display("%0t:          actual   res=%h lt=%b eq=%b gt=%b dz=%b",
                                 $realtime, response.result, response.a_less,
                                 response.a_equal, response.a_greater,
                                 response.divide_by_zero);
                        errors <= errors + 1;
                    end
                end
            end
        end
        pending <= expected_responses.size();
    end

    initial
    begin
        errors  = 0;
        pending = 0;
    end
endmodule

// ===== test/testbench.sv =====
// Top of the fixed-point ALU testbench: stimulus, clock, reset and verdict.
module testbench;
    import fpa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAC_BITS = 8;
    localparam int LATENCY = FRAC_BITS + 36;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors;
    int   pending;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    longint cycles = 0;

    fpa_in_if  request();
    fpa_out_if response();

    fixed_point_alu_unit #(.FRAC_BITS(FRAC_BITS)) dut (
        .clk(clk), .rst_n(rst_n), .request(request), .response(response));

    fpa_checker #(.FRAC_BITS(FRAC_BITS)) checker_i (
        .clk(clk), .rst_n(rst_n), .request(request), .response(response),
        .errors(errors), .pending(pending));

    // Clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver stalls
    always @(posedge clk)
        response.ready <= ($urandom_range(99) >= recv_stall_pct);

    // Pick an operand that often lands on an edge value
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return $urandom_range(2048) - 1024;
            default: return $urandom;
        endcase
    endfunction

    // Present one request and hold it until accepted; ready is settled
    // between edges, so it is looked at mid-cycle before the taking edge
    task automatic send_request(input logic [3:0] cmd, input logic [31:0] a,
                                input logic [31:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            request.valid <= 1'b0;
            @(posedge clk);
        end
        request.valid     <= 1'b1;
        request.command   <= cmd;
        request.operand_a <= a;
        request.operand_b <= b;
        @(negedge clk);
        while (!request.ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        logic [3:0] cmd;
        request.valid     = 1'b0;
        request.command   = '0;
        request.operand_a = '0;
        request.operand_b = '0;
        response.ready    = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every command, on edge values, plus unused codes
        send_request(CMD_ADD, 32'h7fff_ffff, 32'h0000_0001);
        send_request(CMD_SUB, 32'h8000_0000, 32'h0000_0001);
        send_request(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
        send_request(CMD_MUL, 32'hffff_ffff, 32'h0000_0001);
        send_request(CMD_DIV, 32'h0000_1234, 32'h0000_0000);
        send_request(CMD_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_request(CMD_DIV, 32'hffff_fff0, 32'h0000_0300);
        send_request(CMD_MIN, 32'h8000_0000, 32'h7fff_ffff);
        send_request(CMD_MAX, 32'h8000_0000, 32'h7fff_ffff);
        send_request(CMD_MIN, 32'h0000_0005, 32'h0000_0005);
        send_request(CMD_INC, 32'h7fff_ffff, 32'h0);
        send_request(CMD_DEC, 32'h8000_0000, 32'h0);
        send_request(CMD_TO_INT, 32'hffff_ff01, 32'h0);
        send_request(CMD_TO_INT, 32'h7fff_ffff, 32'h7fff_ffff);
        send_request(CMD_FROM_INT, 32'h0080_0001, 32'hffff_ffff);
        send_request(4'd10, 32'h1, 32'h2);
        send_request(4'd15, 32'hffff_ffff, 32'hffff_fffe);

        // Pause until the pipe has drained; the count is registered, so it trails
        request.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        // Random traffic through the idling phases
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1 || phase == 3) ? 62 : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? 62 : 0;
            if (phase == 3)
            begin
                send_idle_pct  = 16;
                recv_stall_pct = 16;
            end
            for (int i = 0; i < 250; i++)
            begin
                cmd = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10))
                                                : 4'($urandom_range(9));
                send_request(cmd, pick_operand(), pick_operand());
            end
        end
        request.valid <= 1'b0;
        recv_stall_pct = 0;

        // Drain, then allow stray responses to show
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
